/* rtl/matrix_multiply_core_macros.svh */
// assertion macros shared by the matrix multiply core modules
// no dependencies; included by the modules that carry checks
`ifndef MATRIX_MULTIPLY_CORE_MACROS_SVH
`define MATRIX_MULTIPLY_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MMC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define MMC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mmc_pkg.sv */
// types and constants of the matrix multiply core
// no dependencies; used by every module of the core except mmc_store
`timescale 1ns / 1ps

package mmc_pkg;

    localparam int ELEM_W    = 16;
    localparam int FRAC_BITS = 8;
    localparam int PROD_W    = 2 * ELEM_W;
    // room for the sum of eight products of two elements
    localparam int ACC_W     = 2 * ELEM_W + 3;
    localparam int IDX_W     = 3;
    localparam int DIM_W     = 4;
    localparam int TDATA_W   = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (ELEM_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_COMPUTE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_FINISH
    } state_t;

    typedef struct packed {
        op_t                      kind;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [ELEM_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

endpackage

/* rtl/mmc_front.sv */
// front end: accepts input beats, drops ignored items, pushes commands
// depends on mmc_pkg
`timescale 1ns / 1ps

module mmc_front #(
    parameter int MAX_DIM = 8
) (
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [1:0]                 s_tuser,
    input  logic [mmc_pkg::IDX_W-1:0]  s_row,
    input  logic [mmc_pkg::IDX_W-1:0]  s_col,
    input  logic signed [mmc_pkg::ELEM_W-1:0] s_value,
    input  mmc_pkg::q_status_t         q_stat,
    output logic                       push,
    output mmc_pkg::cmd_t              push_cmd
);

    logic in_range;
    logic keep;

    assign s_tready = !q_stat.full;

    always_comb begin
        in_range = ({1'b0, s_row} < 4'(MAX_DIM)) && ({1'b0, s_col} < 4'(MAX_DIM));
        keep     = 1'b0;
        if (s_tuser inside {mmc_pkg::OP_WRITE_A, mmc_pkg::OP_WRITE_B}) begin
            keep = in_range;
        end else if (s_tuser == mmc_pkg::OP_COMPUTE) begin
            keep = 1'b1;
        end
    end

    // unused opcode and writes outside the store are consumed and dropped
    assign push = s_tvalid && s_tready && keep;

    always_comb begin
        push_cmd.kind  = mmc_pkg::op_t'(s_tuser);
        push_cmd.row   = s_row;
        push_cmd.col   = s_col;
        push_cmd.value = s_value;
    end

endmodule

/* rtl/mmc_queue.sv */
// short command queue between front and back end
// depends on mmc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "matrix_multiply_core_macros.svh"

module mmc_queue #(
    parameter int DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  mmc_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output mmc_pkg::cmd_t      head,
    output mmc_pkg::q_status_t q_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    mmc_pkg::cmd_t  fifo_mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW:0]    count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign head             = fifo_mem[rd_ptr_reg];
    assign q_stat.not_empty = (count_reg != '0);
    assign q_stat.full      = (count_reg == (PW + 1)'(DEPTH));

    `MMC_ASSERT_IMP(a_no_push_full, aclk, aresetn, push, !q_stat.full, "push into full queue")
    `MMC_ASSERT_IMP(a_no_pop_empty, aclk, aresetn, pop, count_reg != '0, "pop from empty queue")
    `MMC_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= (PW + 1)'(DEPTH),
        "queue count beyond depth")

endmodule

/* rtl/mmc_store.sv */
// matrix element memory with per-entry valid bits; unwritten entries read zero
// depends on nothing but its parameters
`timescale 1ns / 1ps

module mmc_store #(
    parameter int DEPTH = 64,
    parameter int W     = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic signed [W-1:0]                      wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic signed [W-1:0]                      rd_data
);

    logic signed [W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]    vld_reg;
    logic signed [W-1:0] data_q_reg;
    logic                vld_q_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        data_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            vld_q_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = vld_q_reg ? data_q_reg : '0;

endmodule

/* rtl/mmc_back.sv */
// back end: executes queued commands, sequences the multiply-accumulate
// pipeline and holds the result register; depends on mmc_pkg and macros
`timescale 1ns / 1ps
`include "matrix_multiply_core_macros.svh"

module mmc_back #(
    parameter int MAX_DIM = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic [mmc_pkg::DIM_W-1:0]              rows_a,
    input  logic [mmc_pkg::DIM_W-1:0]              inner_dim,
    input  logic [mmc_pkg::DIM_W-1:0]              cols_b,
    input  mmc_pkg::q_status_t                     q_stat,
    input  mmc_pkg::cmd_t                          q_head,
    output logic                                   pop,
    output logic                                   a_wr_en,
    output logic                                   b_wr_en,
    output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] wr_addr,
    output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] a_rd_addr,
    output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] b_rd_addr,
    input  logic signed [mmc_pkg::ELEM_W-1:0]      a_data,
    input  logic signed [mmc_pkg::ELEM_W-1:0]      b_data,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [mmc_pkg::TDATA_W-1:0]            m_tdata,  // value, row, col
    output logic [0:0]                             m_tuser,  // saturated
    output logic                                   m_tlast
);

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

    mmc_pkg::state_t state_reg, state_next;

    logic [IW-1:0] i_reg, j_reg, k_reg;
    logic [IW-1:0] nr_last_reg, nk_last_reg, nc_last_reg;
    logic          v1_reg, v2_reg;
    logic signed [mmc_pkg::PROD_W-1:0] prod_reg;
    logic signed [mmc_pkg::ACC_W-1:0]  acc_reg;

    logic                               m_valid_reg;
    logic signed [mmc_pkg::ELEM_W-1:0]  m_value_reg;
    logic [mmc_pkg::IDX_W-1:0]          m_row_reg, m_col_reg;
    logic                               m_sat_reg, m_last_reg;

    logic start, issue, emit_out, out_free, pipe_empty, last_elem;
    logic signed [mmc_pkg::ACC_W-1:0]  shifted;
    logic signed [mmc_pkg::ELEM_W-1:0] sat_value;
    logic                              sat_flag;

    // clamp a dimension register to 1..MAX_DIM and return its last index
    function automatic logic [IW-1:0] last_idx(input logic [mmc_pkg::DIM_W-1:0] d);
        logic [mmc_pkg::DIM_W-1:0] c;
        c = d;
        if (d == '0) begin
            c = 4'd1;
        end else if (d > 4'(MAX_DIM)) begin
            c = 4'(MAX_DIM);
        end
        return IW'(c - 4'd1);
    endfunction

    assign out_free   = !m_valid_reg || m_tready;
    assign pipe_empty = !v1_reg && !v2_reg;
    assign last_elem  = (i_reg == nr_last_reg) && (j_reg == nc_last_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mmc_pkg::ST_IDLE: begin
                if (q_stat.not_empty && q_head.kind == mmc_pkg::OP_COMPUTE) begin
                    state_next = mmc_pkg::ST_MAC;
                end
            end
            mmc_pkg::ST_MAC: begin
                if (k_reg == nk_last_reg) begin
                    state_next = mmc_pkg::ST_FINISH;
                end
            end
            mmc_pkg::ST_FINISH: begin
                if (pipe_empty && out_free) begin
                    state_next = last_elem ? mmc_pkg::ST_IDLE : mmc_pkg::ST_MAC;
                end
            end
            default: state_next = mmc_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        pop      = 1'b0;
        issue    = 1'b0;
        emit_out = 1'b0;
        case (state_reg)
            mmc_pkg::ST_IDLE:   pop      = q_stat.not_empty;
            mmc_pkg::ST_MAC:    issue    = 1'b1;
            mmc_pkg::ST_FINISH: emit_out = pipe_empty && out_free;
            default: ;
        endcase
        a_wr_en = pop && (q_head.kind == mmc_pkg::OP_WRITE_A);
        b_wr_en = pop && (q_head.kind == mmc_pkg::OP_WRITE_B);
        start   = pop && (q_head.kind == mmc_pkg::OP_COMPUTE);
    end

    assign wr_addr   = AW'(int'(q_head.row) * MAX_DIM + int'(q_head.col));
    assign a_rd_addr = AW'(int'(i_reg) * MAX_DIM + int'(k_reg));
    assign b_rd_addr = AW'(int'(k_reg) * MAX_DIM + int'(j_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mmc_pkg::ST_IDLE;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            acc_reg     <= '0;
        end else begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            if (start) begin
                i_reg <= '0;
                j_reg <= '0;
                k_reg <= '0;
            end else begin
                if (issue) begin
                    k_reg <= (k_reg == nk_last_reg) ? '0 : k_reg + 1'b1;
                end
                if (emit_out) begin
                    if (j_reg == nc_last_reg) begin
                        j_reg <= '0;
                        i_reg <= (i_reg == nr_last_reg) ? '0 : i_reg + 1'b1;
                    end else begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
            end
            if (start || emit_out) begin
                acc_reg <= '0;
            end else if (v2_reg) begin
                acc_reg <= acc_reg + mmc_pkg::ACC_W'(prod_reg);
            end
            if (emit_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (start) begin
            nr_last_reg <= last_idx(rows_a);
            nk_last_reg <= last_idx(inner_dim);
            nc_last_reg <= last_idx(cols_b);
        end
        prod_reg <= a_data * b_data;
        if (emit_out) begin
            m_value_reg <= sat_value;
            m_row_reg   <= mmc_pkg::IDX_W'(i_reg);
            m_col_reg   <= mmc_pkg::IDX_W'(j_reg);
            m_sat_reg   <= sat_flag;
            m_last_reg  <= last_elem;
        end
    end

    // floor shift then clip to element range
    always_comb begin
        shifted   = acc_reg >>> mmc_pkg::FRAC_BITS;
        sat_flag  = 1'b0;
        sat_value = shifted[mmc_pkg::ELEM_W-1:0];
        if (shifted > mmc_pkg::SAT_HI) begin
            sat_flag  = 1'b1;
            sat_value = mmc_pkg::SAT_HI[mmc_pkg::ELEM_W-1:0];
        end else if (shifted < mmc_pkg::SAT_LO) begin
            sat_flag  = 1'b1;
            sat_value = mmc_pkg::SAT_LO[mmc_pkg::ELEM_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_col_reg, m_row_reg, m_value_reg};
    assign m_tuser  = m_sat_reg;
    assign m_tlast  = m_last_reg;

    `MMC_ASSERT_IMP(a_idle_pipe_empty, aclk, aresetn, state_reg == mmc_pkg::ST_IDLE,
        pipe_empty, "mac pipeline busy while idle")
    `MMC_ASSERT_NXT(a_start_clean, aclk, aresetn, start,
        state_reg == mmc_pkg::ST_MAC && k_reg == '0 && acc_reg == '0,
        "product run did not start clean")
    `MMC_ASSERT_IMP(a_k_in_range, aclk, aresetn, state_reg == mmc_pkg::ST_MAC,
        k_reg <= nk_last_reg, "inner index beyond dimension")

endmodule

/* rtl/matrix_multiply_core.sv */
// write items are stored by the back end as they leave the queue and stream at one beat per cycle
// while the queue has room and the back end is idle; a compute item yields an R x C product with
// inner dimension K: per element, K multiply-accumulates through one multiplier, then a pipeline
// drain and the output register load, which waits while the output is stalled.
// synchronous active-low reset: dimensions return to 8, both stores read as zero,
// the command queue empties; no clearing pass is needed
`timescale 1ns / 1ps

module matrix_multiply_core #(
    parameter int MAX_DIM = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mmc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mmc_pkg::DIM_W-1:0]           cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mmc_pkg::TDATA_W-1:0]         s_tdata,  // row_index, col_index, element_value
    input  logic [1:0]                          s_tuser,  // operation
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mmc_pkg::TDATA_W-1:0]         m_tdata,  // product_value, out_row, out_col
    output logic [0:0]                          m_tuser,  // saturated
    output logic                                m_tlast
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;

    logic [mmc_pkg::DIM_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;

    mmc_pkg::q_status_t q_stat;
    mmc_pkg::cmd_t      push_cmd, q_head;
    logic               push, pop;
    logic               a_wr_en, b_wr_en;
    logic [AW-1:0]      wr_addr, a_rd_addr, b_rd_addr;
    logic signed [mmc_pkg::ELEM_W-1:0] a_data, b_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg    <= mmc_pkg::DIM_RESET;
            inner_dim_reg <= mmc_pkg::DIM_RESET;
            cols_b_reg    <= mmc_pkg::DIM_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mmc_pkg::CFG_ROWS_A:    rows_a_reg    <= cfg_wdata;
                mmc_pkg::CFG_INNER_DIM: inner_dim_reg <= cfg_wdata;
                mmc_pkg::CFG_COLS_B:    cols_b_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    mmc_front #(.MAX_DIM(MAX_DIM)) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_row    (s_tdata[2:0]),
        .s_col    (s_tdata[5:3]),
        .s_value  (s_tdata[21:6]),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    mmc_queue #(.DEPTH(4)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (q_head),
        .q_stat   (q_stat)
    );

    mmc_store #(.DEPTH(DEPTH), .W(mmc_pkg::ELEM_W)) u_a_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (a_wr_en),
        .wr_addr (wr_addr),
        .wr_data (q_head.value),
        .rd_addr (a_rd_addr),
        .rd_data (a_data)
    );

    mmc_store #(.DEPTH(DEPTH), .W(mmc_pkg::ELEM_W)) u_b_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (b_wr_en),
        .wr_addr (wr_addr),
        .wr_data (q_head.value),
        .rd_addr (b_rd_addr),
        .rd_data (b_data)
    );

    mmc_back #(.MAX_DIM(MAX_DIM)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rows_a    (rows_a_reg),
        .inner_dim (inner_dim_reg),
        .cols_b    (cols_b_reg),
        .q_stat    (q_stat),
        .q_head    (q_head),
        .pop       (pop),
        .a_wr_en   (a_wr_en),
        .b_wr_en   (b_wr_en),
        .wr_addr   (wr_addr),
        .a_rd_addr (a_rd_addr),
        .b_rd_addr (b_rd_addr),
        .a_data    (a_data),
        .b_data    (b_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
